[src/ffha_pkg.sv]
// Package: types and constants for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int HEAP_BYTES   = 1048576;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_BLOCKS   = 256;
  localparam int SPLIT_SLACK  = 16;
  localparam int SLOT_W       = $clog2(MAX_BLOCKS);
  localparam int LINK_W       = SLOT_W + 1;
  localparam int OFS_W        = 20;
  localparam logic [31:0] BASE_RESET = 32'h0020_0000;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_OOM      = 3'd2;
  localparam logic [2:0] ST_NULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [20:0] request_size;
    logic [31:0] free_address;
  } ffha_in_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
    logic [20:0] used_bytes;
    logic [20:0] free_bytes;
  } ffha_out_t;

endpackage

[src/first_fit_heap_allocator.sv]
// Top level: first-fit heap allocator with split and forward merge.
// Usage:
//   in_valid/in_ready/in_data carries one request item (alloc or free).
//   out_valid/out_ready/out_data returns one result item per request.
//   cfg_we/cfg_wdata write heap_base; write only while idle.
// Sequence: a request walks the block list one descriptor at a time
//   (memory read, then check); an alloc that splits also scans the slot
//   map for a spare slot, one slot at a time (read, then check). A
//   zero-size or null request is answered from idle without a list walk.
// Throughput: one request at a time; in_ready is low while busy and while
//   a result waits in the output register.
// Reset: a clearing pass writes the descriptor and slot memories, one slot
//   per cycle, through all MAX_BLOCKS slots; then slot zero covers the heap
//   minus one header.
// Stall: a result holds in the output register until out_ready is high.
`timescale 1ns / 1ps
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ffha_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ffha_out_t out_data,
  input  logic      cfg_we,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_CHK   = 10'b0000001000,
    S_SCAN  = 10'b0000010000,
    S_SPLIT = 10'b0000100000,
    S_NXRD  = 10'b0001000000,
    S_MERGE = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_TRD   = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic [OFS_W-1:0]  ofs;
    logic [OFS_W-1:0]  size;
    logic              is_free;
    logic [LINK_W-1:0] next;
  } desc_t;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_BLOCKS);

  desc_t mem [MAX_BLOCKS];
  logic  taken_mem [MAX_BLOCKS];

  state_t state_r;
  logic [31:0] base_r;
  logic [20:0] used_r;
  ffha_in_t req_r;
  logic [21:0] size_r;
  logic [SLOT_W-1:0] cur_r, scan_r;
  logic [SLOT_W:0] steps_r;
  desc_t rd_r, cd_r;
  logic [SLOT_W-1:0] rd_addr;
  logic we;
  logic [SLOT_W-1:0] wa;
  desc_t wd;
  logic tk_r;
  logic tk_we;
  logic [SLOT_W-1:0] tk_wa;
  logic tk_wd;
  logic [SLOT_W:0] clr_r;
  ffha_out_t out_r;
  logic [31:0] daddr;
  logic [SLOT_W-1:0] nx_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;
  assign daddr     = base_r + 32'(rd_r.ofs) + 32'(HEADER_BYTES);
  assign nx_idx    = cd_r.next[SLOT_W-1:0];

  always_comb begin
    rd_addr = cur_r;
    if (state_r == S_NXRD) rd_addr = nx_idx;
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    tk_r <= taken_mem[scan_r];
    if (tk_we) taken_mem[tk_wa] <= tk_wd;
  end

  task automatic finish(input logic [2:0] st, input logic [31:0] a,
                        input logic [20:0] u);
    out_r.result_address <= a;
    out_r.status         <= st;
    out_r.used_bytes     <= u;
    out_r.free_bytes     <= 21'(HEAP_BYTES) - u;
    state_r              <= S_OUT;
  endtask

  always_comb begin
    we    = 1'b0;
    wa    = cur_r;
    wd    = cd_r;
    tk_we = 1'b0;
    tk_wa = scan_r;
    tk_wd = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_r[SLOT_W-1:0];
        wd = '{ofs: '0, size: '0, is_free: 1'b0, next: NIL};
        if (clr_r == '0) begin
          wd.size    = OFS_W'(HEAP_BYTES - HEADER_BYTES);
          wd.is_free = 1'b1;
        end
        tk_we = 1'b1;
        tk_wa = clr_r[SLOT_W-1:0];
        tk_wd = (clr_r == '0);
      end
      S_CHK: begin
        if (req_r.req_type == REQ_ALLOC) begin
          if (rd_r.is_free && {2'b0, rd_r.size} >= size_r &&
              !({2'b0, rd_r.size} > size_r + 22'(HEADER_BYTES + SPLIT_SLACK))) begin
            we = 1'b1;
            wd = rd_r;
            wd.is_free = 1'b0;
          end
        end else if (!rd_r.is_free && daddr == req_r.free_address) begin
          we = 1'b1;
          wd = rd_r;
          wd.is_free = 1'b1;
        end
      end
      S_SCAN: begin
        if (!tk_r || scan_r == SLOT_W'(MAX_BLOCKS - 1)) begin
          we = 1'b1;
          wd = cd_r;
          wd.is_free = 1'b0;
          if (!tk_r) begin
            wd.size = size_r[OFS_W-1:0];
            wd.next = {1'b0, scan_r};
            tk_we   = 1'b1;
          end
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        wa = scan_r;
        wd.ofs     = cd_r.ofs + OFS_W'(HEADER_BYTES) + size_r[OFS_W-1:0];
        wd.size    = cd_r.size - size_r[OFS_W-1:0] - OFS_W'(HEADER_BYTES);
        wd.is_free = 1'b1;
        wd.next    = cd_r.next;
      end
      S_MERGE: begin
        if (rd_r.is_free) begin
          we = 1'b1;
          wd = cd_r;
          wd.is_free = 1'b1;
          wd.size = cd_r.size + rd_r.size + OFS_W'(HEADER_BYTES);
          wd.next = rd_r.next;
          tk_we = 1'b1;
          tk_wa = nx_idx;
          tk_wd = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      base_r  <= BASE_RESET;
      used_r  <= '0;
    end else begin
      if (cfg_we) base_r <= cfg_wdata;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (SLOT_W+1)'(MAX_BLOCKS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            size_r  <= ({1'b0, in_data.request_size} + 22'd3) & ~22'd3;
            cur_r   <= '0;
            steps_r <= '0;
            if (in_data.req_type == REQ_ALLOC && in_data.request_size == '0)
              finish(ST_ZERO, '0, used_r);
            else if (in_data.req_type == REQ_FREE && in_data.free_address == '0)
              finish(ST_NULL, '0, used_r);
            else
              state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          cd_r    <= rd_r;
          steps_r <= steps_r + 1'b1;
          if (req_r.req_type == REQ_ALLOC) begin
            if (rd_r.is_free && {2'b0, rd_r.size} >= size_r) begin
              if ({2'b0, rd_r.size} > size_r + 22'(HEADER_BYTES + SPLIT_SLACK)) begin
                scan_r  <= '0;
                state_r <= S_TRD;
              end else begin
                used_r <= used_r + 21'(rd_r.size);
                finish(ST_OK, daddr, used_r + 21'(rd_r.size));
              end
            end else if (rd_r.next == NIL || steps_r == (SLOT_W+1)'(MAX_BLOCKS - 1)) begin
              finish(ST_OOM, '0, used_r);
            end else begin
              cur_r   <= rd_r.next[SLOT_W-1:0];
              state_r <= S_RD;
            end
          end else begin
            if (!rd_r.is_free && daddr == req_r.free_address) begin
              used_r <= used_r - 21'(rd_r.size);
              if (rd_r.next == NIL) finish(ST_OK, '0, used_r - 21'(rd_r.size));
              else state_r <= S_NXRD;
            end else if (rd_r.next == NIL || steps_r == (SLOT_W+1)'(MAX_BLOCKS - 1)) begin
              finish(ST_NOTFOUND, '0, used_r);
            end else begin
              cur_r   <= rd_r.next[SLOT_W-1:0];
              state_r <= S_RD;
            end
          end
        end
        S_TRD: state_r <= S_SCAN;
        S_SCAN: begin
          if (!tk_r) begin
            state_r <= S_SPLIT;
          end else if (scan_r == SLOT_W'(MAX_BLOCKS - 1)) begin
            used_r <= used_r + 21'(cd_r.size);
            finish(ST_OK, base_r + 32'(cd_r.ofs) + 32'(HEADER_BYTES),
                   used_r + 21'(cd_r.size));
          end else begin
            scan_r  <= scan_r + 1'b1;
            state_r <= S_TRD;
          end
        end
        S_SPLIT: begin
          used_r <= used_r + size_r[20:0];
          finish(ST_OK, base_r + 32'(cd_r.ofs) + 32'(HEADER_BYTES),
                 used_r + size_r[20:0]);
        end
        S_NXRD: state_r <= S_MERGE;
        S_MERGE: finish(ST_OK, '0, used_r);
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
